// ===== rtl/roman_numeral_encoder_unit_assert.svh =====
// assertion macros for the roman numeral encoder unit
// used by roman_numeral_encoder_unit.sv, expects clk_i and rst_ni in scope
`ifndef ROMAN_NUMERAL_ENCODER_UNIT_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RNE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rne property violated");
`define RNE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rne forbidden condition seen");
`else
`define RNE_ASSERT(lbl, prop)
`define RNE_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/rne_pkg.sv =====
// shared types, constants and letter tables of the roman numeral encoder
// no dependencies
`timescale 1ns / 1ps

package rne_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned REM_W   = 14;  // holds up to nine times a thousand
  localparam int unsigned LEN_W   = 3;   // longest digit pattern is four letters
  localparam int unsigned POS_W   = 2;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 16'd4000;

  localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
  localparam logic [CHAR_W-1:0] CH_I    = 7'h69;
  localparam logic [CHAR_W-1:0] CH_V    = 7'h76;
  localparam logic [CHAR_W-1:0] CH_X    = 7'h78;
  localparam logic [CHAR_W-1:0] CH_L    = 7'h6c;
  localparam logic [CHAR_W-1:0] CH_C    = 7'h63;
  localparam logic [CHAR_W-1:0] CH_D    = 7'h64;
  localparam logic [CHAR_W-1:0] CH_M    = 7'h6d;
  localparam logic [CHAR_W-1:0] CH_STAR = 7'h2a;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MODE_ROMAN,
    MODE_STAR,
    MODE_EMPTY
  } run_mode_e;

  typedef enum logic [1:0] {
    KIND_ONE,
    KIND_FIVE,
    KIND_TEN
  } letter_kind_e;

  typedef struct packed {
    logic load;
    logic split;
    logic advance;
  } rne_cmd_t;

  typedef struct packed {
    logic split_zero;
    logic digit_end;
    logic run_last;
  } rne_status_t;

  // weight of one step of decimal place p
  function automatic logic [REM_W-1:0] place_power(input logic [1:0] p);
    logic [REM_W-1:0] w;
    case (p)
      2'd0:    w = 14'd1;
      2'd1:    w = 14'd10;
      2'd2:    w = 14'd100;
      default: w = 14'd1000;
    endcase
    return w;
  endfunction

  function automatic logic [REM_W-1:0] place_mult(input logic [1:0] p,
                                                  input logic [3:0] k);
    logic [REM_W+3:0] prod;
    prod = place_power(p) * {{REM_W{1'b0}}, k};
    return prod[REM_W-1:0];
  endfunction

  // number of letters for decimal digit d
  function automatic logic [LEN_W-1:0] digit_len(input logic [3:0] d);
    logic [LEN_W-1:0] n;
    case (d)
      4'd1, 4'd5:       n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:             n = 3'd2;
      4'd3, 4'd7:       n = 3'd3;
      4'd8:             n = 3'd4;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  // which letter stands at position j of digit d
  function automatic letter_kind_e letter_kind(input logic [3:0] d,
                                               input logic [POS_W-1:0] j);
    letter_kind_e k;
    k = KIND_ONE;
    case (d)
      4'd4:                     if (j != 2'd0) k = KIND_FIVE;
      4'd9:                     if (j != 2'd0) k = KIND_TEN;
      4'd5, 4'd6, 4'd7, 4'd8:   if (j == 2'd0) k = KIND_FIVE;
      default:                  k = KIND_ONE;
    endcase
    return k;
  endfunction

  function automatic logic [CHAR_W-1:0] roman_letter(input logic [1:0] p,
                                                     input letter_kind_e k);
    logic [CHAR_W-1:0] c;
    case (k)
      KIND_FIVE: begin
        case (p)
          2'd0:    c = CH_V;
          2'd1:    c = CH_L;
          2'd2:    c = CH_D;
          default: c = CH_STAR;
        endcase
      end
      KIND_TEN: begin
        case (p)
          2'd0:    c = CH_X;
          2'd1:    c = CH_C;
          2'd2:    c = CH_M;
          default: c = CH_STAR;
        endcase
      end
      default: begin
        case (p)
          2'd0:    c = CH_I;
          2'd1:    c = CH_X;
          2'd2:    c = CH_C;
          default: c = CH_M;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/rne_in_if.sv =====
// request channel of the roman numeral encoder: one signed value per request
// depends on rne_pkg
`timescale 1ns / 1ps

interface rne_in_if import rne_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/rne_out_if.sv =====
// result channel of the roman numeral encoder: one character per transfer
// depends on rne_pkg
`timescale 1ns / 1ps

interface rne_out_if import rne_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_empty;
  logic              last;

  modport source (output valid, output character, output is_empty, output last,
                  input ready);
  modport sink   (input valid, input character, input is_empty, input last,
                  output ready);
endinterface

// ===== rtl/rne_ctrl.sv =====
// controller of the roman numeral encoder: idle, digit split and emit phases
// depends on rne_pkg
`timescale 1ns / 1ps

module rne_ctrl import rne_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        out_ready_i,
  input  rne_status_t status_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output rne_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SPLIT;
      end
      ST_SPLIT: begin
        // a zero digit has no letters, go on to the next place
        if (!status_i.split_zero) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (status_i.run_last) begin
            state_d = ST_IDLE;
          end else if (status_i.digit_end) begin
            state_d = ST_SPLIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.split   = 1'b0;
    cmd_o.advance = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
      end
      ST_EMIT: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/rne_datapath.sv =====
// datapath of the roman numeral encoder: remainder, digit split, letter lookup
// depends on rne_pkg
`timescale 1ns / 1ps

module rne_datapath import rne_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rne_cmd_t                  cmd_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output rne_status_t               status_o,
  output logic [CHAR_W-1:0]         character_o,
  output logic                      is_empty_o,
  output logic                      last_o
);

  run_mode_e         mode_q, mode_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [1:0]        split_place_q, split_place_d;
  logic [1:0]        emit_place_q, emit_place_d;
  logic [3:0]        digit_q, digit_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  logic              value_empty;
  logic              value_star;
  logic [3:0]        split_digit;
  logic              digit_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EMPTY;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    split_place_q <= split_place_d;
    emit_place_q  <= emit_place_d;
    digit_q       <= digit_d;
    len_q         <= len_d;
    pos_q         <= pos_d;
  end

  assign value_empty = value_i[VALUE_W-1] || (value_i == '0);
  assign value_star  = !value_i[VALUE_W-1] && ($unsigned(value_i) >= VALUE_LIMIT);

  // digit = number of multiples of the place weight that fit in the remainder
  always_comb begin
    split_digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_q >= place_mult(split_place_q, 4'(k))) split_digit = split_digit + 4'd1;
    end
  end

  always_comb begin
    mode_d        = mode_q;
    rem_d         = rem_q;
    split_place_d = split_place_q;
    emit_place_d  = emit_place_q;
    digit_d       = digit_q;
    len_d         = len_q;
    pos_d         = pos_q;
    if (cmd_i.load) begin
      split_place_d = 2'd3;
      rem_d         = {2'b00, value_i[11:0]};
      if (value_empty) begin
        mode_d = MODE_EMPTY;
      end else if (value_star) begin
        mode_d = MODE_STAR;
      end else begin
        mode_d = MODE_ROMAN;
      end
    end else if (cmd_i.split) begin
      pos_d = '0;
      case (mode_q)
        MODE_ROMAN: begin
          digit_d       = split_digit;
          len_d         = digit_len(split_digit);
          rem_d         = rem_q - place_mult(split_place_q, split_digit);
          emit_place_d  = split_place_q;
          split_place_d = split_place_q - 2'd1;
        end
        MODE_STAR: len_d = 3'd2;
        default:   len_d = 3'd1;
      endcase
    end else if (cmd_i.advance) begin
      pos_d = pos_q + 2'd1;
    end
  end

  assign digit_end = ({1'b0, pos_q} == (len_q - 3'd1));

  assign status_o.split_zero = (mode_q == MODE_ROMAN) && (split_digit == 4'd0);
  assign status_o.digit_end  = digit_end;
  assign status_o.run_last   = digit_end && ((mode_q != MODE_ROMAN) || (rem_q == '0));

  always_comb begin
    case (mode_q)
      MODE_ROMAN: character_o = roman_letter(emit_place_q, letter_kind(digit_q, pos_q));
      MODE_STAR:  character_o = CH_STAR;
      default:    character_o = CH_NONE;
    endcase
  end

  assign is_empty_o = (mode_q == MODE_EMPTY);
  assign last_o     = status_o.run_last;

endmodule

// ===== rtl/roman_numeral_encoder_unit.sv =====
// roman numeral encoder unit, top level: controller plus datapath
// depends on rne_pkg, rne_in_if, rne_out_if, rne_ctrl, rne_datapath and the
// assertion header roman_numeral_encoder_unit_assert.svh
//
// Takes one signed 16-bit value per request and returns its lower-case roman
// numeral as a run of ASCII characters, most significant first, one character
// per result transfer, with last set on the final one. Zero or negative values
// give a single result with is_empty set and character 0; values of 4000 or
// more give the two characters "**". One request is worked on at a time: the
// request port is ready only while the unit is idle. A request with an ordinary
// value is accepted, then split one decimal place at a time from the thousands
// down to the lowest nonzero digit (at most 4 places), and the characters of each
// digit are sent while the result side is ready; special values take a single
// split step. The flow is set by the result port moving one character per cycle
// while the result side is ready and by the one-place-per-cycle digit split unit.
// Back-pressure on the result side simply holds the current character.
`timescale 1ns / 1ps

`include "roman_numeral_encoder_unit_assert.svh"

module roman_numeral_encoder_unit import rne_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  rne_in_if.sink     req_i,
  rne_out_if.source  res_o
);

  // command and status between controller and datapath
  rne_cmd_t    cmd;
  rne_status_t status;

  // controller: sequences idle, per-place split and per-character emit
  rne_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  // datapath: classifies the value, splits digits, looks up letters
  rne_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (req_i.value),
    .status_o    (status),
    .character_o (res_o.character),
    .is_empty_o  (res_o.is_empty),
    .last_o      (res_o.last)
  );

  // a new request is never taken while a character is pending
  `RNE_NEVER(a_no_overlap, req_i.ready && res_o.valid)
  // an empty result is always a lone, last result with no character
  `RNE_ASSERT(a_empty_alone, res_o.valid && res_o.is_empty |-> res_o.last && (res_o.character == CH_NONE))
  // a real character is never code 0
  `RNE_ASSERT(a_char_nonzero, res_o.valid && !res_o.is_empty |-> (res_o.character != CH_NONE))
  // after the last character moves, the unit goes back to idle
  `RNE_ASSERT(a_run_ends, res_o.valid && res_o.ready && res_o.last |=> !res_o.valid && req_i.ready)

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for roman_numeral_encoder_unit: drives signed values,
// predicts each character run and checks every result transfer against it
// depends on rne_pkg, rne_in_if, rne_out_if and the unit itself
`timescale 1ns / 1ps

module tb_top;
  import rne_pkg::*;

  localparam int unsigned RANDOM_VALUES = 136;
  localparam int unsigned DRAIN_CYCLES  = 64;    // well past the worst run
  localparam realtime     RUN_LIMIT     = 2ms;   // far above the slowest legal run

  // one expected character transfer
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              is_empty;
    logic              last;
  } numeral_char_t;

  logic clk_i;
  logic rst_ni;

  rne_in_if  req_if ();
  rne_out_if res_if ();

  roman_numeral_encoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // values still to be offered, filled up front by the stimulus block
  logic signed [VALUE_W-1:0] pending_values[$];
  // characters the unit still owes, oldest first
  numeral_char_t             numeral_q[$];
  // scratch run of letters built by the predictor
  logic [CHAR_W-1:0]         letter_run[$];

  logic        req_fire_q = 1'b0;  // request taken at the last rising edge
  logic        res_fire_q = 1'b0;  // result taken at the last rising edge
  int unsigned req_gap    = 0;
  int unsigned res_stall  = 0;

  logic [31:0] req_count   = '0;
  int unsigned char_count  = 0;
  int unsigned empty_count = 0;
  int unsigned star_count  = 0;
  int unsigned fail_count  = 0;

  // idle pattern rotates every 32 requests: both sides idle, only the result
  // side idles, only the request side idles, then a stretch with no idling
  logic [1:0] idle_phase;
  logic       quiet_req;
  logic       quiet_res;
  assign idle_phase = req_count[6:5];
  assign quiet_req  = idle_phase[0];
  assign quiet_res  = idle_phase[1];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // letters of one decimal digit at a given place (0 = units)
  function automatic void append_digit(input int unsigned place, input int unsigned d);
    logic [CHAR_W-1:0] one;
    logic [CHAR_W-1:0] five;
    logic [CHAR_W-1:0] ten;
    int unsigned       ones;
    case (place)
      0: begin
        one = CH_I; five = CH_V; ten = CH_X;
      end
      1: begin
        one = CH_X; five = CH_L; ten = CH_C;
      end
      2: begin
        one = CH_C; five = CH_D; ten = CH_M;
      end
      default: begin
        one = CH_M; five = CH_STAR; ten = CH_STAR;
      end
    endcase
    if (d == 4) begin
      // subtractive four: one-letter before five-letter
      letter_run.push_back(one);
      letter_run.push_back(five);
    end else if (d == 9) begin
      // subtractive nine: one-letter before ten-letter
      letter_run.push_back(one);
      letter_run.push_back(ten);
    end else if (d != 0) begin
      ones = d;
      if (d >= 5) begin
        letter_run.push_back(five);
        ones = d - 5;
      end
      repeat (ones) letter_run.push_back(one);
    end
  endfunction

  // expected character run of one accepted value, appended to numeral_q
  function automatic void predict_numeral(input logic signed [VALUE_W-1:0] v);
    numeral_char_t r;
    int unsigned   n;
    letter_run.delete();
    if (v <= 0) begin
      // zero or negative: a single empty marker
      r.character = CH_NONE;
      r.is_empty  = 1'b1;
      r.last      = 1'b1;
      numeral_q.push_back(r);
      empty_count++;
    end else begin
      if (v >= VALUE_LIMIT) begin
        // out of range: two stars
        letter_run.push_back(CH_STAR);
        letter_run.push_back(CH_STAR);
        star_count++;
      end else begin
        n = v;
        append_digit(3, n / 1000);
        append_digit(2, (n % 1000) / 100);
        append_digit(1, (n % 100) / 10);
        append_digit(0, n % 10);
      end
      foreach (letter_run[k]) begin
        r.character = letter_run[k];
        r.is_empty  = 1'b0;
        r.last      = (k == letter_run.size() - 1);
        numeral_q.push_back(r);
      end
    end
  endfunction

  // request driver: changes on the falling edge, holds a request until taken,
  // then waits its drawn gap before offering the next value
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire_q) begin
      if (req_gap != 0) begin
        req_if.valid <= 1'b0;
        req_gap      <= req_gap - 1;
      end else if (pending_values.size() != 0) begin
        req_if.valid <= 1'b1;
        req_if.value <= pending_values.pop_front();
        req_gap      <= quiet_req ? 0 : $urandom_range(0, 15);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result sink: after each taken result, draw how long ready stays low
  always @(negedge clk_i) begin : res_sink
    int unsigned stall_next;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      stall_next = res_fire_q ? (quiet_res ? 0 : $urandom_range(0, 15)) : res_stall;
      if (stall_next != 0) begin
        res_if.ready <= 1'b0;
        res_stall    <= stall_next - 1;
      end else begin
        res_if.ready <= 1'b1;
        res_stall    <= 0;
      end
    end
  end

  // monitor: samples both channels on the rising edge, predicts on each
  // taken request and checks each taken result against the oldest expectation
  always @(posedge clk_i) begin : monitor
    numeral_char_t want;
    req_fire_q <= rst_ni && req_if.valid && req_if.ready;
    res_fire_q <= rst_ni && res_if.valid && res_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) begin
      predict_numeral(req_if.value);
      req_count <= req_count + 1;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      char_count++;
      if (numeral_q.size() == 0) begin
        $error("unexpected result: character %h is_empty %b last %b",
               res_if.character, res_if.is_empty, res_if.last);
        fail_count++;
      end else begin
        want = numeral_q.pop_front();
        if (res_if.character !== want.character) begin
          $error("character mismatch: expected %h, actual %h",
                 want.character, res_if.character);
          fail_count++;
        end
        if (res_if.is_empty !== want.is_empty) begin
          $error("is_empty mismatch: expected %b, actual %b",
                 want.is_empty, res_if.is_empty);
          fail_count++;
        end
        if (res_if.last !== want.last) begin
          $error("last mismatch: expected %b, actual %b", want.last, res_if.last);
          fail_count++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int unsigned pick;
    // every input known from time zero
    req_if.valid = 1'b0;
    req_if.value = '0;
    res_if.ready = 1'b0;
    rst_ni       = 1'b0;

    // directed: range ends, zero, each subtractive form at each place,
    // the longest run, the largest ordinary value and the overflow boundary
    pending_values = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd4, 16'sd5, 16'sd9,
                       16'sd10, 16'sd14, 16'sd40, 16'sd49, 16'sd90, 16'sd99, 16'sd400,
                       16'sd444, 16'sd900, 16'sd999, 16'sd1000, 16'sd1994, 16'sd3888,
                       16'sd3999, 16'sd4000, 16'sd4001, 16'sd32767};

    // random: mostly ordinary values, with empties, overflows and raw noise
    repeat (RANDOM_VALUES) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       pending_values.push_back(VALUE_W'($urandom()));
        1:       pending_values.push_back(VALUE_W'($urandom_range(4000, 32767)));
        2:       pending_values.push_back(-$signed({1'b0, 15'($urandom())}));
        3:       pending_values.push_back(VALUE_W'($urandom_range(1, 99)));
        default: pending_values.push_back(VALUE_W'($urandom_range(1, 3999)));
      endcase
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for every request to go out and every character to come back
    while (pending_values.size() != 0 || req_if.valid || numeral_q.size() != 0)
      @(posedge clk_i);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d values converted (%0d empty, %0d overflow), %0d characters checked",
             req_count, empty_count, star_count, char_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT);
    $display("tb: timeout with %0d characters still owed", numeral_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule
